@@ rtl/wss_pkg.sv @@
// Shared types, constants and microcode for the wheel speed sensor block.
`timescale 1ns / 1ps
package wss_pkg;

   // Field and register widths
   localparam int TICK_W        = 32;
   localparam int RPM_FRAC_BITS = 8;
   localparam int RATE_W        = 20;
   localparam int MINP_W        = 20;
   localparam int TMO_W         = 22;
   localparam int START_W       = 22;
   localparam int CIRC_W        = 13;
   localparam int RPM_W         = 18;
   localparam int SPEED_W       = 16;
   localparam int ODO_W         = 40;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 22;

   // Register reset values
   localparam int RATE_RESET    = 10000;
   localparam int MINP_RESET    = 900;
   localparam int TMO_RESET     = 30000;
   localparam int START_RESET   = 40000;
   localparam int CIRC_RESET    = 2073;
   localparam int ODO_RESET     = 1000;

   // Compare width for tick differences against the config limits
   localparam int CMP_W = (TICK_W > TMO_W) ? TICK_W : TMO_W;

   // rpm numerator: rate * 60 * 2^F = (rate * 15) << (F + 2)
   localparam int NUM_SH = RPM_FRAC_BITS + 2;
   localparam int NUM_W  = RATE_W + 4 + NUM_SH;
   localparam int CNT_W  = $clog2(NUM_W);

   // speed = floor((avg * circ) >> (F + 2)) / 15), the /15 by reciprocal
   localparam int PROD1_W = RPM_W + CIRC_W;
   localparam int YSH     = NUM_SH;
   localparam int YW      = PROD1_W - YSH;
   localparam int RSH     = YW + 4;
   localparam int RW      = RSH - 3;
   localparam longint RECIP = ((longint'(1) << RSH) + 64'sd14) / 64'sd15;
   localparam int PROD2_W = YW + RW;
   localparam int PROD_W  = (PROD1_W > PROD2_W) ? PROD1_W : PROD2_W;
   localparam int MA_W    = (RPM_W > YW) ? RPM_W : YW;
   localparam int MB_W    = (CIRC_W > RW) ? CIRC_W : RW;
   localparam int SPD_RAW_W = PROD2_W - RSH;

   // Microcode store
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] A_ACCEPT   = PC_W'(0);
   localparam logic [PC_W-1:0] A_DIV_STEP = PC_W'(5);
   localparam logic [PC_W-1:0] A_TIMEOUT  = PC_W'(8);
   localparam logic [PC_W-1:0] A_SPEED    = PC_W'(13);
   localparam logic [PC_W-1:0] A_EMIT     = PC_W'((1 << PC_W) - 1);

   typedef enum logic [2:0] {
      CSR_TICK_RATE  = 3'd0,
      CSR_MIN_PERIOD = 3'd1,
      CSR_TIMEOUT    = 3'd2,
      CSR_STARTUP    = 3'd3,
      CSR_CIRC       = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_TIMING,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_AVG,
      OP_ODO,
      OP_TIMEOUT,
      OP_MUL_RAW,
      OP_MUL_RECIP,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_NOT_FALL,
      C_SHORT,
      C_DIV_BUSY,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic fall;
      logic short_period;
      logic div_busy;
      logic out_busy;
   } flags_type;

   typedef struct packed {
      logic [RATE_W-1:0]  tick_rate;
      logic [MINP_W-1:0]  min_period;
      logic [TMO_W-1:0]   timeout;
      logic [START_W-1:0] startup;
      logic [CIRC_W-1:0]  circ;
   } cfg_type;

   // Control program: execute op, then jump to target if cond holds, else step on.
   // The emit step sits at the top address so that falling through wraps to accept.
   function automatic ctrl_type ucode_word(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: A_ACCEPT};
      case (pc)
         A_ACCEPT:    w = '{op: OP_ACCEPT,    cond: C_NO_REQ,   target: A_ACCEPT};
         PC_W'(1):    w = '{op: OP_TIMING,    cond: C_NEVER,    target: A_ACCEPT};
         PC_W'(2):    w = '{op: OP_NOP,       cond: C_NOT_FALL, target: A_TIMEOUT};
         PC_W'(3):    w = '{op: OP_NOP,       cond: C_SHORT,    target: A_SPEED};
         PC_W'(4):    w = '{op: OP_DIV_INIT,  cond: C_NEVER,    target: A_ACCEPT};
         A_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY, target: A_DIV_STEP};
         PC_W'(6):    w = '{op: OP_AVG,       cond: C_NEVER,    target: A_ACCEPT};
         PC_W'(7):    w = '{op: OP_ODO,       cond: C_ALWAYS,   target: A_SPEED};
         A_TIMEOUT:   w = '{op: OP_TIMEOUT,   cond: C_ALWAYS,   target: A_SPEED};
         A_SPEED:     w = '{op: OP_MUL_RAW,   cond: C_NEVER,    target: A_ACCEPT};
         PC_W'(14):   w = '{op: OP_MUL_RECIP, cond: C_NEVER,    target: A_ACCEPT};
         A_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: A_EMIT};
         default:     w = '{op: OP_NOP,       cond: C_ALWAYS,   target: A_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/wss_csr.sv @@
// Configuration registers of the wheel speed sensor block.
`timescale 1ns / 1ps
module wss_csr
   import wss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_idx_type'(csr_index))
            CSR_TICK_RATE:  cfg_in.tick_rate  = csr_wdata[RATE_W-1:0];
            CSR_MIN_PERIOD: cfg_in.min_period = csr_wdata[MINP_W-1:0];
            CSR_TIMEOUT:    cfg_in.timeout    = csr_wdata[TMO_W-1:0];
            CSR_STARTUP:    cfg_in.startup    = csr_wdata[START_W-1:0];
            CSR_CIRC:       cfg_in.circ       = csr_wdata[CIRC_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_rate  <= RATE_W'(RATE_RESET);
         cfg_ff.min_period <= MINP_W'(MINP_RESET);
         cfg_ff.timeout    <= TMO_W'(TMO_RESET);
         cfg_ff.startup    <= START_W'(START_RESET);
         cfg_ff.circ       <= CIRC_W'(CIRC_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/wss_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps
module wss_seq
   import wss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            jump;

   assign ctrl = ucode_word(pc_ff);

   always_comb begin
      case (ctrl.cond)
         C_NEVER:    jump = 1'b0;
         C_ALWAYS:   jump = 1'b1;
         C_NO_REQ:   jump = !req_valid;
         C_NOT_FALL: jump = !flags.fall;
         C_SHORT:    jump = flags.short_period;
         C_DIV_BUSY: jump = flags.div_busy;
         C_OUT_BUSY: jump = flags.out_busy;
         default:    jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : PC_W'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTHESIS
   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_ACCEPT && !req_valid) |=> (pc_ff == $past(pc_ff)))
      else $error("sequencer left the accept step without a transfer");
`endif

endmodule

@@ rtl/wss_dp.sv @@
// Datapath: tick timing, serial divider, shared multiplier, state and result register.
`timescale 1ns / 1ps
module wss_dp
   import wss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_type           ctrl,
   input  cfg_type            cfg,
   output flags_type          flags,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_sensor_level,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [RPM_W-1:0]   rsp_rpm_filtered_q8,
   output logic [SPEED_W-1:0] rsp_speed_mm_per_s,
   output logic [ODO_W-1:0]   rsp_distance_mm,
   output logic               rsp_edge_taken
);

   // block state
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              prev_ff, prev_in;
   logic [TICK_W-1:0] last_ff, last_in;
   logic [RPM_W-1:0]  avg_ff, avg_in;
   logic [ODO_W-1:0]  odo_ff, odo_in;
   logic              past_ff, past_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic              level_ff, level_in;
   logic              taken_ff, taken_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic [TICK_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [RPM_W-1:0]   rsp_rpm_ff, rsp_rpm_in;
   logic [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic [ODO_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic               rsp_taken_ff, rsp_taken_in;

   logic                   accept, emit;
   logic [RATE_W+3:0]      rate15;
   logic [NUM_W-1:0]       numer;
   logic [TICK_W:0]        rem_sh, rem_diff;
   logic [RPM_W-1:0]       rpm_sat;
   logic [RPM_W:0]         avg_sum;
   logic [ODO_W:0]         odo_sum;
   logic [MA_W-1:0]        mul_a;
   logic [MB_W-1:0]        mul_b;
   logic [MA_W+MB_W-1:0]   mul_full;
   logic [SPD_RAW_W-1:0]   spd_raw;
   logic [SPEED_W-1:0]     spd_sat;

   assign accept    = (ctrl.op == OP_ACCEPT) && req_valid;
   assign req_ready = (ctrl.op == OP_ACCEPT);
   assign emit      = (ctrl.op == OP_EMIT) && !flags.out_busy;

   assign flags.fall         = prev_ff && !level_ff;
   assign flags.short_period = !(CMP_W'(elapsed_ff) > CMP_W'(cfg.min_period));
   assign flags.div_busy     = (cnt_ff != CNT_W'(NUM_W - 1));
   assign flags.out_busy     = rsp_valid_ff && !rsp_ready;

   // 60 * rate * 2^F as (16 - 1) * rate, shifted
   assign rate15 = {cfg.tick_rate, 4'b0000} - (RATE_W + 4)'(cfg.tick_rate);
   assign numer  = {rate15, NUM_SH'(0)};

   // one restoring divide step
   assign rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, elapsed_ff};

   assign rpm_sat = (quo_ff > NUM_W'((1 << RPM_W) - 1)) ? '1 : quo_ff[RPM_W-1:0];
   assign avg_sum = {1'b0, avg_ff} + {1'b0, rpm_sat};
   assign odo_sum = {1'b0, odo_ff} + (ODO_W + 1)'(cfg.circ);

   always_comb begin
      case (ctrl.op)
         OP_MUL_RAW: begin
            mul_a = MA_W'(avg_ff);
            mul_b = MB_W'(cfg.circ);
         end
         OP_MUL_RECIP: begin
            mul_a = MA_W'(prod_ff[YSH +: YW]);
            mul_b = MB_W'(RECIP);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   assign spd_raw = prod_ff[RSH +: SPD_RAW_W];
   assign spd_sat = (SPD_RAW_W'(spd_raw) > SPD_RAW_W'((1 << SPEED_W) - 1)) ?
                    '1 : SPEED_W'(spd_raw);

   always_comb begin
      tick_in      = tick_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      avg_in       = avg_ff;
      odo_in       = odo_ff;
      past_in      = past_ff;
      cnt_in       = cnt_ff;
      level_in     = level_ff;
      taken_in     = taken_ff;
      elapsed_in   = elapsed_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      prod_in      = prod_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_taken_in = rsp_taken_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (ctrl.op)
         OP_ACCEPT: begin
            if (accept) begin
               level_in = req_sensor_level;
               tick_in  = TICK_W'(tick_ff + 1'b1);
               taken_in = 1'b0;
            end
         end
         OP_TIMING: begin
            if (CMP_W'(tick_ff) > CMP_W'(cfg.startup)) begin
               past_in = 1'b1;
            end
            elapsed_in = tick_ff - last_ff;
         end
         OP_DIV_INIT: begin
            rem_in   = '0;
            quo_in   = numer;
            cnt_in   = '0;
            taken_in = 1'b1;
            last_in  = tick_ff;
         end
         OP_DIV_STEP: begin
            if (!rem_diff[TICK_W]) begin
               rem_in = rem_diff[TICK_W-1:0];
            end else begin
               rem_in = rem_sh[TICK_W-1:0];
            end
            quo_in = {quo_ff[NUM_W-2:0], !rem_diff[TICK_W]};
            cnt_in = CNT_W'(cnt_ff + 1'b1);
         end
         OP_AVG: begin
            avg_in = avg_sum[RPM_W:1];
         end
         OP_ODO: begin
            if (past_ff) begin
               odo_in = odo_sum[ODO_W] ? '1 : odo_sum[ODO_W-1:0];
            end
         end
         OP_TIMEOUT: begin
            if (CMP_W'(elapsed_ff) > CMP_W'(cfg.timeout)) begin
               avg_in = '0;
            end
         end
         OP_MUL_RAW, OP_MUL_RECIP: begin
            prod_in = PROD_W'(mul_full);
         end
         OP_EMIT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_rpm_in   = avg_ff;
               rsp_speed_in = spd_sat;
               rsp_dist_in  = odo_ff;
               rsp_taken_in = taken_ff;
               prev_in      = level_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         prev_ff      <= 1'b0;
         last_ff      <= '0;
         avg_ff       <= '0;
         odo_ff       <= ODO_W'(ODO_RESET);
         past_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         avg_ff       <= avg_in;
         odo_ff       <= odo_in;
         past_ff      <= past_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      taken_ff     <= taken_in;
      elapsed_ff   <= elapsed_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      prod_ff      <= prod_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_taken_ff <= rsp_taken_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rpm_filtered_q8 = rsp_rpm_ff;
   assign rsp_speed_mm_per_s  = rsp_speed_ff;
   assign rsp_distance_mm     = rsp_dist_ff;
   assign rsp_edge_taken      = rsp_taken_ff;

`ifndef SYNTHESIS
   a_odo_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (odo_ff >= $past(odo_ff)))
      else $error("odometer went backwards");

   a_avg_owner: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && avg_ff != $past(avg_ff)) |->
         ($past(ctrl.op) == OP_AVG || $past(ctrl.op) == OP_TIMEOUT))
      else $error("filtered rpm changed outside its update steps");

   a_taken_stamp: assert property (@(posedge clock) disable iff (reset)
      (emit && taken_ff) |-> (last_ff == tick_ff))
      else $error("accepted edge without matching edge timestamp");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(ctrl.op) == OP_EMIT))
      else $error("result raised outside the emit step");
`endif

endmodule

@@ rtl/wheel_speed_sensor_rpm_odometer_top.sv @@
// Top level of the wheel speed sensor rpm, speedometer and odometer block.
`timescale 1ns / 1ps
// Usage:
//  - req_*: one transfer per timer tick carrying the sampled sensor pin level.
//    The block counts ticks, times falling edges and updates its filtered rpm
//    and odometer; every request yields exactly one rsp_* transfer.
//  - rsp_*: filtered rpm (Q.8), speed in mm/s, trip distance in mm and a flag
//    for an accepted falling edge, held in an output register.
//  - csr_*: write-only registers, one write per cycle with csr_wen high; write
//    them only while no tick is in flight. Unknown indexes are ignored.
// Processing: a tick without an accepted edge skips the divider and goes on
// to the speed multiply; an accepted edge first runs the 34-step restoring
// divider of the period-to-rpm conversion. One tick is in work at a time;
// req_ready is high only while the sequencer waits in its accept step.
// Reset (synchronous, active high) restores the register defaults, clears the
// tick counter, filter and start-up flag and presets the odometer to 1000 mm.
// A stalled receiver is fine: the next request is taken and computed while a
// result waits; the sequencer only holds in its final step until the output
// register frees up.
module wheel_speed_sensor_rpm_odometer_top
   import wss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick samples in
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_sensor_level,
   // results out
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RPM_W-1:0]      rsp_rpm_filtered_q8,
   output logic [SPEED_W-1:0]    rsp_speed_mm_per_s,
   output logic [ODO_W-1:0]      rsp_distance_mm,
   output logic                  rsp_edge_taken,
   // register writes
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg;
   ctrl_type  ctrl;
   flags_type flags;

   // register file
   wss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // control store and step counter; jumps on datapath flags
   wss_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .flags     (flags),
      .ctrl      (ctrl)
   );

   // timing, divider, multiplier, state and result register
   wss_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .cfg                 (cfg),
      .flags               (flags),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sensor_level    (req_sensor_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rpm_filtered_q8 (rsp_rpm_filtered_q8),
      .rsp_speed_mm_per_s  (rsp_speed_mm_per_s),
      .rsp_distance_mm     (rsp_distance_mm),
      .rsp_edge_taken      (rsp_edge_taken)
   );

endmodule
